// ===== rtl/stpd_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stpd_pkg
// Shared types and constants of the statement tokenizer.
// ---------------------------------------------------------------------------
package stpd_pkg;

  // Counters hold up to the largest supported limit (64).
  localparam int CNT_W   = 7;
  localparam int DEPTH_W = 6;
  localparam logic [DEPTH_W-1:0] DEPTH_MAX = 6'd63;

  // Request queue between front and back.
  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  // Character codes.
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_DOT   = 8'h2E;

  // Error codes.
  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_UNBAL   = 2'd1;
  localparam logic [1:0] ERR_TOKENS  = 2'd2;
  localparam logic [1:0] ERR_TOOLONG = 2'd3;

  typedef struct packed {
    logic [4:0] idx;
    logic [4:0] pos;
    logic       has;
    logic [7:0] ch;
    logic       tend;
    logic       done;
    logic [5:0] count;
    logic [1:0] err;
    logic       last;
  } res_t;

  // One accepted character: one or two results.
  typedef struct packed {
    logic two;
    res_t r1;
    res_t r0;
  } desc_t;

endpackage

// ===== rtl/statement_tokenizer_paren_depth.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// statement_tokenizer_paren_depth
// Splits a statement, one character per request, into tokens, tracking
// parenthesis depth, and reports stored characters, token ends, statement
// end and errors as result requests.
// ---------------------------------------------------------------------------
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------------
//  in_     | in        | in_valid / in_ready  | in_char
//  out_    | out       | out_valid / out_ready| token_index, char_pos, has_char,
//          |           |                      | out_char, token_end, stmt_done,
//          |           |                      | token_count, error_code, last
//
// Cycles: one character is taken per cycle while in_ready is high; the front
// updates depth and counters in the cycle it accepts. Results leave one per
// cycle from the back while out_ready is high; a character may yield two.
// Reset: synchronous, active low; counters, depth and queue pointers clear.
// Stalls: a four-deep request queue sits between front and back; in_ready
// drops only when it is full.
// ---------------------------------------------------------------------------
module statement_tokenizer_paren_depth import stpd_pkg::*; #(
  parameter int MAX_TOKENS    = 32,
  parameter int MAX_TOKEN_LEN = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [4:0] out_token_index,
  output logic [4:0] out_char_pos,
  output logic       out_has_char,
  output logic [7:0] out_char,
  output logic       out_token_end,
  output logic       out_stmt_done,
  output logic [5:0] out_token_count,
  output logic [1:0] out_error_code,
  output logic       out_last
);

  logic  acc, push, pop, full, nempty;
  desc_t wdesc, head;
  res_t  res;

  // Front is ready whenever the queue has room.
  assign in_ready = !full;
  assign acc      = in_valid && in_ready;

  stpd_front #(
    .MAX_TOKENS    (MAX_TOKENS),
    .MAX_TOKEN_LEN (MAX_TOKEN_LEN)
  ) u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .acc   (acc),
    .chr   (in_char),
    .push  (push),
    .desc  (wdesc)
  );

  stpd_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wdata  (wdesc),
    .pop    (pop),
    .full   (full),
    .nempty (nempty),
    .rdata  (head)
  );

  stpd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .nempty    (nempty),
    .head      (head),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .res       (res),
    .pop       (pop)
  );

  assign out_token_index = res.idx;
  assign out_char_pos    = res.pos;
  assign out_has_char    = res.has;
  assign out_char        = res.ch;
  assign out_token_end   = res.tend;
  assign out_stmt_done   = res.done;
  assign out_token_count = res.count;
  assign out_error_code  = res.err;
  assign out_last        = res.last;

endmodule

// ===== rtl/stpd_front.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stpd_front
// Classifies each character, updates depth and counters, builds results.
// ---------------------------------------------------------------------------
module stpd_front import stpd_pkg::*; #(
  parameter int MAX_TOKENS    = 32,
  parameter int MAX_TOKEN_LEN = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       acc,
  input  logic [7:0] chr,
  output logic       push,
  output desc_t      desc
);

  logic [DEPTH_W-1:0] depth_r, depth_nxt;
  logic [CNT_W-1:0]   tok_r, tok_nxt;
  logic [CNT_W-1:0]   len_r, len_nxt;

  logic is_delim, is_lpar, is_rpar, is_term, is_sym, is_plain;
  logic open, c_vld, s_vld, e_vld, done;
  logic [1:0] err;
  logic [CNT_W-1:0] tok_aft, tok_cur, len_cur;
  res_t c_res, s_res, lst;

  always_comb begin
    is_delim = (chr == CH_COMMA) || (chr == CH_SPACE) || (chr == CH_LF);
    is_lpar  = (chr == CH_LPAR);
    is_rpar  = (chr == CH_RPAR);
    is_term  = (chr == CH_SEMI) || (chr == CH_NUL);
    is_sym   = (chr == CH_EQ) || (chr == CH_LT) || (chr == CH_GT) || (chr == CH_DOT);
    is_plain = !(is_delim || is_lpar || is_rpar || is_term || is_sym);

    open    = (len_r != '0);
    tok_aft = tok_r + CNT_W'(open);
    c_vld   = open && !is_plain;

    c_res       = '0;
    c_res.idx   = tok_r[4:0];
    c_res.pos   = len_r[4:0];
    c_res.tend  = 1'b1;

    s_res     = '0;
    s_vld     = 1'b0;
    done      = 1'b0;
    err       = ERR_NONE;
    depth_nxt = depth_r;
    tok_nxt   = tok_aft;
    len_nxt   = '0;
    tok_cur   = tok_aft;
    len_cur   = '0;

    priority if (is_lpar) begin
      if (depth_r != DEPTH_MAX) depth_nxt = depth_r + 1'b1;
    end else if (is_rpar) begin
      if (depth_r == '0) begin
        err = ERR_UNBAL;
      end else begin
        depth_nxt = depth_r - 1'b1;
        done      = (depth_r == DEPTH_W'(1));
      end
    end else if (is_term) begin
      done = 1'b1;
    end else if (is_sym) begin
      if (tok_aft >= CNT_W'(MAX_TOKENS)) begin
        err = ERR_TOKENS;
      end else begin
        s_vld      = 1'b1;
        s_res.idx  = tok_aft[4:0];
        s_res.has  = 1'b1;
        s_res.ch   = chr;
        s_res.tend = 1'b1;
        tok_nxt    = tok_aft + 1'b1;
      end
    end else if (is_plain) begin
      tok_nxt = tok_r;
      len_nxt = len_r;
      tok_cur = tok_r;
      len_cur = len_r;
      if (tok_r >= CNT_W'(MAX_TOKENS)) begin
        err = ERR_TOKENS;
      end else if (len_r >= CNT_W'(MAX_TOKEN_LEN)) begin
        err = ERR_TOOLONG;
      end else begin
        s_vld     = 1'b1;
        s_res.idx = tok_r[4:0];
        s_res.pos = len_r[4:0];
        s_res.has = 1'b1;
        s_res.ch  = chr;
        len_nxt   = len_r + 1'b1;
      end
    end else begin
      // plain delimiter: only the close of the open token
    end

    // Empty result carrying a statement end or an error.
    e_vld = (done || (err != ERR_NONE)) && !c_vld;
    if (e_vld) begin
      s_vld     = 1'b1;
      s_res     = '0;
      s_res.idx = tok_cur[4:0];
      s_res.pos = len_cur[4:0];
    end

    if (done || (err != ERR_NONE)) begin
      depth_nxt = '0;
      tok_nxt   = '0;
      len_nxt   = '0;
    end

    lst       = s_vld ? s_res : c_res;
    lst.done  = done;
    lst.count = done ? tok_aft[5:0] : 6'd0;
    lst.err   = err;
    lst.last  = 1'b1;

    desc.two = c_vld && s_vld;
    desc.r1  = lst;
    desc.r0  = (c_vld && s_vld) ? c_res : lst;
    push     = acc && (c_vld || s_vld);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
      tok_r   <= '0;
      len_r   <= '0;
    end else if (acc) begin
      depth_r <= depth_nxt;
      tok_r   <= tok_nxt;
      len_r   <= len_nxt;
    end
  end

endmodule

// ===== rtl/stpd_queue.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stpd_queue
// Small request queue decoupling the front from the result sequencer.
// ---------------------------------------------------------------------------
module stpd_queue import stpd_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  desc_t wdata,
  input  logic  pop,
  output logic  full,
  output logic  nempty,
  output desc_t rdata
);

  desc_t mem [QDEPTH];
  logic [QAW-1:0] wp_r, rp_r;
  logic [QAW:0]   cnt_r, cnt_nxt;

  assign full   = (cnt_r == (QAW+1)'(QDEPTH));
  assign nempty = (cnt_r != '0);
  assign rdata  = mem[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) mem[wp_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/stpd_back.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stpd_back
// Issues the one or two results of the head request, one per cycle while out_ready is high.
// ---------------------------------------------------------------------------
module stpd_back import stpd_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  nempty,
  input  desc_t head,
  input  logic  out_ready,
  output logic  out_valid,
  output res_t  res,
  output logic  pop
);

  logic phase_r, phase_nxt;
  logic fire;

  always_comb begin
    out_valid = nempty;
    res       = phase_r ? head.r1 : head.r0;
    fire      = nempty && out_ready;
    pop       = fire && (phase_r || !head.two);
    phase_nxt = phase_r;
    if (fire) phase_nxt = !pop;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
    end
  end

endmodule

// ===== sim/tb_statement_tokenizer_paren_depth.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_statement_tokenizer_paren_depth
// Self-checking bench for the statement tokenizer: a queue-fed driver sends
// characters, a clocked predictor works out the result requests, and a
// monitor checks every result field by field under random idling.
// ---------------------------------------------------------------------------
module tb_statement_tokenizer_paren_depth;
  import stpd_pkg::*;

  localparam int MAX_TOKENS    = 32;
  localparam int MAX_TOKEN_LEN = 32;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_char;
  logic       out_valid;
  logic       out_ready;
  logic [4:0] out_token_index;
  logic [4:0] out_char_pos;
  logic       out_has_char;
  logic [7:0] out_char;
  logic       out_token_end;
  logic       out_stmt_done;
  logic [5:0] out_token_count;
  logic [1:0] out_error_code;
  logic       out_last;

  statement_tokenizer_paren_depth #(
    .MAX_TOKENS   (MAX_TOKENS),
    .MAX_TOKEN_LEN(MAX_TOKEN_LEN)
  ) DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_char        (in_char),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_token_index(out_token_index),
    .out_char_pos   (out_char_pos),
    .out_has_char   (out_has_char),
    .out_char       (out_char),
    .out_token_end  (out_token_end),
    .out_stmt_done  (out_stmt_done),
    .out_token_count(out_token_count),
    .out_error_code (out_error_code),
    .out_last       (out_last)
  );

  // Characters waiting to be sent, and results the tokenizer still owes us.
  logic [7:0] char_feed[$];
  res_t       pending_results[$];

  // Predictor state: nesting depth saturates, counters are plain integers.
  logic [5:0] nest_depth;
  int         tok_cnt;
  int         chr_cnt;

  int send_idle_pct;
  int recv_idle_pct;
  logic in_took;       // request accepted at the last rising edge

  int mismatches;
  int chars_taken;
  int results_checked;
  int stmts_done;
  int err_seen[4];
  int deepest;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

  task automatic report_mismatch(string msg);
    $display("MISMATCH @%0t result %0d: %s", $realtime, results_checked, msg);
    mismatches++;
  endtask

  task automatic flag_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
  endtask

  function automatic res_t make_res(int idx, int pos, logic has, logic [7:0] ch,
                                    logic tend);
    res_t r;
    r      = '0;
    r.idx  = idx[4:0];
    r.pos  = pos[4:0];
    r.has  = has;
    r.ch   = ch;
    r.tend = tend;
    return r;
  endfunction

  // Predictor: one accepted character in, zero to two results queued.
  task automatic tokenize_char(logic [7:0] c);
    res_t       rs[2];
    int         n;
    logic       fin;
    logic [1:0] err;
    logic       splits;
    n      = 0;
    fin    = 1'b0;
    err    = ERR_NONE;
    splits = (c == CH_COMMA || c == CH_SPACE || c == CH_LF || c == CH_LPAR ||
              c == CH_RPAR || c == CH_SEMI || c == CH_NUL || c == CH_EQ ||
              c == CH_LT || c == CH_GT || c == CH_DOT);
    // any break character closes an open token first
    if (splits && chr_cnt != 0) begin
      rs[n] = make_res(tok_cnt, chr_cnt, 1'b0, 8'h00, 1'b1);
      n++;
      tok_cnt++;
      chr_cnt = 0;
    end
    case (c)
      CH_COMMA, CH_SPACE, CH_LF: ;
      CH_LPAR: begin
        if (nest_depth != DEPTH_MAX) nest_depth++;
        if (nest_depth > deepest) deepest = nest_depth;
      end
      CH_RPAR: begin
        if (nest_depth == 0) begin
          err = ERR_UNBAL;
        end else begin
          nest_depth--;
          fin = (nest_depth == 0);
        end
      end
      CH_SEMI, CH_NUL: fin = 1'b1;
      CH_EQ, CH_LT, CH_GT, CH_DOT: begin
        if (tok_cnt >= MAX_TOKENS) begin
          err = ERR_TOKENS;
        end else begin
          rs[n] = make_res(tok_cnt, 0, 1'b1, c, 1'b1);
          n++;
          tok_cnt++;
        end
      end
      default: begin
        if (tok_cnt >= MAX_TOKENS) begin
          err = ERR_TOKENS;
        end else if (chr_cnt >= MAX_TOKEN_LEN) begin
          err = ERR_TOOLONG;
        end else begin
          rs[n] = make_res(tok_cnt, chr_cnt, 1'b1, c, 1'b0);
          n++;
          chr_cnt++;
        end
      end
    endcase
    // statement end or error with nothing to carry it: an empty result
    if ((fin || err != ERR_NONE) && (n == 0 || err == ERR_TOOLONG)) begin
      rs[n] = make_res(tok_cnt, chr_cnt, 1'b0, 8'h00, 1'b0);
      n++;
    end
    if (n > 0) begin
      if (fin) begin
        rs[n-1].done  = 1'b1;
        rs[n-1].count = tok_cnt[5:0];
      end
      rs[n-1].err  = err;
      rs[n-1].last = 1'b1;
    end
    for (int i = 0; i < n; i++) pending_results.push_back(rs[i]);
    if (fin || err != ERR_NONE) begin
      nest_depth = '0;
      tok_cnt    = 0;
      chr_cnt    = 0;
    end
  endtask

  // Any byte that is not a delimiter, bracket, terminator or symbol.
  function automatic logic [7:0] plain_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255));
    while (c == CH_COMMA || c == CH_SPACE || c == CH_LF || c == CH_LPAR ||
           c == CH_RPAR || c == CH_SEMI || c == CH_EQ || c == CH_LT ||
           c == CH_GT || c == CH_DOT);
    return c;
  endfunction

  function automatic logic [7:0] pick_symbol();
    case ($urandom_range(0, 3))
      0:       return CH_EQ;
      1:       return CH_LT;
      2:       return CH_GT;
      default: return CH_DOT;
    endcase
  endfunction

  function automatic logic [7:0] pick_gap();
    case ($urandom_range(0, 2))
      0:       return CH_COMMA;
      1:       return CH_SPACE;
      default: return CH_LF;
    endcase
  endfunction

  // Mostly well-formed statements with random content; the rest stresses
  // the limits (long tokens, too many tokens, deep nesting) or is noise.
  task automatic add_random_sequence();
    int pick;
    int lvl;
    int ntok;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      lvl  = 0;
      ntok = $urandom_range(1, 8);
      for (int t = 0; t < ntok; t++) begin
        if ($urandom_range(0, 3) == 0) char_feed.push_back(pick_symbol());
        else repeat ($urandom_range(1, 6)) char_feed.push_back(plain_byte());
        case ($urandom_range(0, 5))
          0, 1: repeat ($urandom_range(1, 2)) char_feed.push_back(pick_gap());
          2: begin
            char_feed.push_back(CH_LPAR);
            lvl++;
          end
          3: begin
            if (lvl > 1) begin
              char_feed.push_back(CH_RPAR);
              lvl--;
            end
          end
          default: ;
        endcase
      end
      if (lvl > 0 && $urandom_range(0, 1) == 1) repeat (lvl) char_feed.push_back(CH_RPAR);
      else char_feed.push_back($urandom_range(0, 3) == 0 ? CH_NUL : CH_SEMI);
    end else if (pick < 67) begin
      // token near or past the length limit
      repeat ($urandom_range(MAX_TOKEN_LEN - 3, MAX_TOKEN_LEN + 3))
        char_feed.push_back(plain_byte());
      char_feed.push_back(pick_gap());
      char_feed.push_back(CH_SEMI);
    end else if (pick < 72) begin
      // token count near or past the limit
      ntok = $urandom_range(MAX_TOKENS - 3, MAX_TOKENS + 3);
      for (int t = 0; t < ntok; t++) begin
        if ($urandom_range(0, 1) == 1) begin
          char_feed.push_back(pick_symbol());
        end else begin
          repeat ($urandom_range(1, 3)) char_feed.push_back(plain_byte());
          char_feed.push_back(CH_SPACE);
        end
      end
      char_feed.push_back(CH_SEMI);
    end else if (pick < 74) begin
      // nesting near or past the depth saturation point
      lvl = $urandom_range(60, 66);
      repeat (lvl) char_feed.push_back(CH_LPAR);
      char_feed.push_back(plain_byte());
      if ($urandom_range(0, 1) == 1) repeat (lvl) char_feed.push_back(CH_RPAR);
      else char_feed.push_back(CH_SEMI);
    end else if (pick < 93) begin
      repeat ($urandom_range(1, 6)) char_feed.push_back(8'($urandom_range(0, 255)));
    end else begin
      char_feed.push_back(CH_RPAR);
    end
  endtask

  // Driver: a new request only once the previous one has been taken.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (char_feed.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_char  <= char_feed.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_ready <= rst_n && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Monitor: predict on each accepted character, check each accepted result.
  always @(posedge clk) begin : monitor
    res_t got;
    res_t want;
    in_took <= rst_n && in_valid && in_ready;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        tokenize_char(in_char);
        chars_taken++;
      end
      if (out_valid && out_ready) begin
        got.idx   = out_token_index;
        got.pos   = out_char_pos;
        got.has   = out_has_char;
        got.ch    = out_char;
        got.tend  = out_token_end;
        got.done  = out_stmt_done;
        got.count = out_token_count;
        got.err   = out_error_code;
        got.last  = out_last;
        if (pending_results.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          want = pending_results.pop_front();
          flag_field("token_index", got.idx,   want.idx);
          flag_field("char_pos",    got.pos,   want.pos);
          flag_field("has_char",    got.has,   want.has);
          flag_field("out_char",    got.ch,    want.ch);
          flag_field("token_end",   got.tend,  want.tend);
          flag_field("stmt_done",   got.done,  want.done);
          flag_field("token_count", got.count, want.count);
          flag_field("error_code",  got.err,   want.err);
          flag_field("last",        got.last,  want.last);
          if (want.done) stmts_done++;
          err_seen[want.err]++;
        end
        results_checked++;
      end
    end
  end

  task automatic wait_drained();
    do @(posedge clk);
    while (char_feed.size() != 0 || in_valid || pending_results.size() != 0);
  endtask

  // Opening checks: byte extremes, every break class, symbol after an open
  // token, ')' closing the statement, stray ')' with and without an open
  // token, empty statement end, NUL end, and ';' with depth still open.
  logic [7:0] opening[] = '{
    8'hFF, 8'h80, 8'h01, CH_COMMA, CH_SPACE, CH_EQ, 8'h61, CH_LT,
    CH_DOT, CH_LF, CH_LPAR, 8'h62, CH_GT, CH_RPAR, CH_RPAR, 8'h63,
    CH_RPAR, CH_SEMI, 8'h64, CH_NUL, CH_LPAR, CH_LPAR, CH_RPAR, CH_SEMI
  };

  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_char         = 8'h00;
    out_ready       = 1'b0;
    in_took         = 1'b0;
    nest_depth      = '0;
    tok_cnt         = 0;
    chr_cnt         = 0;
    mismatches      = 0;
    chars_taken     = 0;
    results_checked = 0;
    stmts_done      = 0;
    deepest         = 0;
    foreach (err_seen[i]) err_seen[i] = 0;
    send_idle_pct   = 35;
    recv_idle_pct   = 80;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // three idling regimes: slow receiver, slow sender, then full rate
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 35;
          recv_idle_pct = 80;
          foreach (opening[i]) char_feed.push_back(opening[i]);
        end
        1: begin
          send_idle_pct = 80;
          recv_idle_pct = 35;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      while (char_feed.size() < 570) add_random_sequence();
      wait_drained();
    end
    repeat (10) @(posedge clk);

    $display("summary: %0d characters, %0d results checked, %0d statements completed",
             chars_taken, results_checked, stmts_done);
    $display("summary: unbalanced %0d, too many tokens %0d, too long %0d, deepest %0d",
             err_seen[ERR_UNBAL], err_seen[ERR_TOKENS], err_seen[ERR_TOOLONG], deepest);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
